@@ src/ms_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types of the merge sorter.
// Used by ms_cell and merge_sorter; depends on nothing.
package ms_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W     = ADDR_W + 1;
   // One merge cell per doubling of the run length, up to the whole set.
   localparam int LEVELS    = ADDR_W;
   localparam int LVL_W     = $clog2(LEVELS) + 1;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_PULL = 1'b1;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // One element moving down the chain of merge cells.
   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic signed [DATA_W-1:0] data;
   } flow_type;

   // Accesses that a cell makes to its two run buffers.
   typedef struct packed {
      logic                     a_wen;
      logic                     b_wen;
      logic [ADDR_W-1:0]        waddr;
      logic signed [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0]        a_raddr;
      logic [ADDR_W-1:0]        b_raddr;
   } ram_req_type;

endpackage

@@ src/ms_cell.sv @@
`timescale 1ns / 1ps
// One merge cell: collects two sorted runs and merges them into one run of twice the length.
// Depends on ms_pkg; its run buffers live in the level that instantiates it.
module ms_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ms_pkg::LVL_W-1:0]          level,
   input  ms_pkg::flow_type                  in_flow,
   output logic                              in_ready,
   output ms_pkg::flow_type                  out_flow,
   input  logic                              out_ready,
   output ms_pkg::ram_req_type               ram_req,
   input  logic signed [ms_pkg::DATA_W-1:0]  rd_a,
   input  logic signed [ms_pkg::DATA_W-1:0]  rd_b
);

   typedef enum logic [3:0] {
      C_LOAD_A = 4'b0001,
      C_LOAD_B = 4'b0010,
      C_PRIME  = 4'b0100,
      C_MERGE  = 4'b1000
   } cell_state_type;

   cell_state_type                    state_ff, state_in;
   logic [ms_pkg::CNT_W-1:0]          na_ff, na_in, nb_ff, nb_in;
   logic [ms_pkg::CNT_W-1:0]          ia_ff, ia_in, ib_ff, ib_in;
   logic                              eos_ff, eos_in;
   logic                              out_valid_ff, out_valid_in;
   logic                              out_last_ff, out_last_in;
   logic signed [ms_pkg::DATA_W-1:0]  out_data_ff, out_data_in;

   logic [ms_pkg::CNT_W-1:0]          run_len;
   logic [ms_pkg::CNT_W-1:0]          na_next, nb_next, ia_next, ib_next;
   logic [ms_pkg::CNT_W-1:0]          used_next, total;
   logic                              in_take, a_left, b_left, take_a, adv, step, done;

   assign run_len   = ms_pkg::CNT_W'(1) << level;
   assign na_next   = na_ff + ms_pkg::CNT_W'(1);
   assign nb_next   = nb_ff + ms_pkg::CNT_W'(1);
   assign ia_next   = ia_ff + ms_pkg::CNT_W'(1);
   assign ib_next   = ib_ff + ms_pkg::CNT_W'(1);
   assign used_next = ia_ff + ib_ff + ms_pkg::CNT_W'(1);
   assign total     = na_ff + nb_ff;

   assign in_ready = (state_ff == C_LOAD_A) || (state_ff == C_LOAD_B);
   assign in_take  = in_flow.valid && in_ready;

   // On ties the first run goes first, which keeps the merge stable.
   assign a_left = ia_ff < na_ff;
   assign b_left = ib_ff < nb_ff;
   assign take_a = a_left && (!b_left || (rd_a <= rd_b));
   assign adv    = !out_valid_ff || out_ready;
   assign step   = (state_ff == C_MERGE) && adv;
   assign done   = used_next == total;

   always_comb begin
      ram_req.a_wen   = in_take && (state_ff == C_LOAD_A);
      ram_req.b_wen   = in_take && (state_ff == C_LOAD_B);
      ram_req.waddr   = (state_ff == C_LOAD_A) ? na_ff[ms_pkg::ADDR_W-1:0]
                                               : nb_ff[ms_pkg::ADDR_W-1:0];
      ram_req.wdata   = in_flow.data;
      // Read ahead so that the next head is in the buffer's output register.
      ram_req.a_raddr = (step && take_a) ? ia_next[ms_pkg::ADDR_W-1:0]
                                         : ia_ff[ms_pkg::ADDR_W-1:0];
      ram_req.b_raddr = (step && !take_a) ? ib_next[ms_pkg::ADDR_W-1:0]
                                          : ib_ff[ms_pkg::ADDR_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      eos_in       = eos_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_last_in  = out_last_ff;
      out_data_in  = out_data_ff;
      case (state_ff)
         C_LOAD_A: begin
            if (in_take) begin
               na_in = na_next;
               if (in_flow.last) begin
                  eos_in   = 1'b1;
                  state_in = C_PRIME;
               end else if (na_next == run_len) begin
                  state_in = C_LOAD_B;
               end
            end
         end
         C_LOAD_B: begin
            if (in_take) begin
               nb_in = nb_next;
               if (in_flow.last) begin
                  eos_in   = 1'b1;
                  state_in = C_PRIME;
               end else if (nb_next == run_len) begin
                  state_in = C_PRIME;
               end
            end
         end
         C_PRIME: begin
            state_in = C_MERGE;
         end
         C_MERGE: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_data_in  = take_a ? rd_a : rd_b;
               out_last_in  = done && eos_ff;
               if (take_a) begin
                  ia_in = ia_next;
               end else begin
                  ib_in = ib_next;
               end
               if (done) begin
                  na_in    = '0;
                  nb_in    = '0;
                  ia_in    = '0;
                  ib_in    = '0;
                  eos_in   = 1'b0;
                  state_in = C_LOAD_A;
               end
            end
         end
         default: begin
            state_in = C_LOAD_A;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_LOAD_A;
         na_ff        <= '0;
         nb_ff        <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         eos_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         eos_ff       <= eos_in;
         out_valid_ff <= out_valid_in;
         out_last_ff  <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign out_flow.valid = out_valid_ff;
   assign out_flow.last  = out_last_ff;
   assign out_flow.data  = out_data_ff;

endmodule

@@ src/merge_sorter.sv @@
`timescale 1ns / 1ps
// Top level of the merge sorter: request and response channels, value store, merge chain.
// Depends on ms_pkg and ms_cell.
//
// Usage. Every request gets exactly one response. A push request (action 0) stores
// value_in and answers at once with status ok, or with status full when the store
// already holds MAX_ITEMS values (the value is dropped). A push with last_in set closes
// the set and starts the sort; a push after a finished sort starts a new set. A pull
// request (action 1) returns the next value in ascending order, with last_out on the
// final one, or status empty when nothing is sorted or everything has been read.
//
// Timing. A push answers in the cycle after it is accepted; a pull passes through the
// PULL state, which takes the value read from the store, and then answers. The sort
// streams the store through a chain of merge cells, one per doubling of the run length,
// and writes the result back into the store. Each cell loads its two runs before it
// merges them and holds its input while merging, so the last cell, which sees the whole
// set twice over, sets the pace. No request is taken during the sort.
//
// Reset clears the counters and the sorted flag; the stores hold no reset value. When
// the receiver stalls, the response stays in its output register and a new request is
// taken only in the cycle in which that response leaves.
module merge_sorter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic signed [ms_pkg::DATA_W-1:0]  req_value_in,
   input  logic                              req_last_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ms_pkg::DATA_W-1:0]  rsp_value_out,
   output logic                              rsp_last_out,
   output logic [1:0]                        rsp_status
);

   typedef enum logic [3:0] {
      TS_IDLE  = 4'b0001,
      TS_PULL  = 4'b0010,
      TS_FEED  = 4'b0100,
      TS_DRAIN = 4'b1000
   } top_state_type;

   localparam int STORE_DEPTH = 1 << ms_pkg::ADDR_W;

   top_state_type                     state_ff, state_in;
   logic [ms_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [ms_pkg::CNT_W-1:0]          rp_ff, rp_in;
   logic                              sorted_ff, sorted_in;
   logic [ms_pkg::CNT_W-1:0]          fptr_ff, fptr_in;
   logic                              pend_ff, pend_in;
   logic [ms_pkg::CNT_W-1:0]          wptr_ff, wptr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [1:0]                        rsp_status_ff, rsp_status_in;
   logic signed [ms_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;

   // The value store: pushes and the chain write it, pulls and the feeder read it.
   logic signed [ms_pkg::DATA_W-1:0]  data_store [0:STORE_DEPTH-1];
   logic signed [ms_pkg::DATA_W-1:0]  store_rd_ff;
   logic                              store_wen;
   logic [ms_pkg::ADDR_W-1:0]         store_waddr, store_raddr;
   logic signed [ms_pkg::DATA_W-1:0]  store_wdata;

   ms_pkg::flow_type                  flow [0:ms_pkg::LEVELS];
   logic                              flow_ready [0:ms_pkg::LEVELS];
   ms_pkg::ram_req_type               ram_req [0:ms_pkg::LEVELS-1];
   logic signed [ms_pkg::DATA_W-1:0]  rd_a_ff [0:ms_pkg::LEVELS-1];
   logic signed [ms_pkg::DATA_W-1:0]  rd_b_ff [0:ms_pkg::LEVELS-1];

   logic                              req_take, is_push, has_room, can_pull, feed_take;
   logic [ms_pkg::CNT_W-1:0]          eff_count, eff_next, push_count;
   logic [ms_pkg::CNT_W-1:0]          rp_next, fptr_next, wptr_next;

   assign req_ready = (state_ff == TS_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign is_push   = req_action == ms_pkg::ACT_PUSH;

   // A push after a finished sort starts a new set from an empty store.
   assign eff_count  = sorted_ff ? '0 : count_ff;
   assign eff_next   = eff_count + ms_pkg::CNT_W'(1);
   assign has_room   = eff_count < ms_pkg::CNT_W'(ms_pkg::MAX_ITEMS);
   assign push_count = has_room ? eff_next : eff_count;
   assign can_pull   = sorted_ff && (rp_ff < count_ff);

   assign rp_next   = rp_ff + ms_pkg::CNT_W'(1);
   assign fptr_next = fptr_ff + ms_pkg::CNT_W'(1);
   assign wptr_next = wptr_ff + ms_pkg::CNT_W'(1);

   // The feeder presents the stored value at fptr; the read runs one ahead on a take.
   assign feed_take = (state_ff == TS_FEED) && pend_ff && flow_ready[0];

   assign flow[0].valid = (state_ff == TS_FEED) && pend_ff;
   assign flow[0].last  = fptr_next == count_ff;
   assign flow[0].data  = store_rd_ff;

   // The store always takes the last cell's output once the sort drains.
   assign flow_ready[ms_pkg::LEVELS] = 1'b1;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rp_in         = rp_ff;
      sorted_in     = sorted_ff;
      fptr_in       = fptr_ff;
      pend_in       = pend_ff;
      wptr_in       = wptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      store_wen     = 1'b0;
      store_waddr   = eff_count[ms_pkg::ADDR_W-1:0];
      store_wdata   = req_value_in;
      store_raddr   = rp_ff[ms_pkg::ADDR_W-1:0];
      case (state_ff)
         TS_IDLE: begin
            if (req_take) begin
               if (is_push) begin
                  count_in      = push_count;
                  rp_in         = sorted_ff ? '0 : rp_ff;
                  sorted_in     = 1'b0;
                  store_wen     = has_room;
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_last_in   = 1'b0;
                  rsp_status_in = has_room ? ms_pkg::STAT_OK : ms_pkg::STAT_FULL;
                  // The set is never empty here: either this value went in or the
                  // store is full.
                  if (req_last_in) begin
                     fptr_in  = '0;
                     pend_in  = 1'b0;
                     wptr_in  = '0;
                     state_in = TS_FEED;
                  end
               end else if (can_pull) begin
                  state_in = TS_PULL;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_last_in   = 1'b0;
                  rsp_status_in = ms_pkg::STAT_EMPTY;
               end
            end
         end
         TS_PULL: begin
            // The store read at rp_ff was issued in the cycle of acceptance.
            rsp_valid_in  = 1'b1;
            rsp_value_in  = store_rd_ff;
            rsp_last_in   = rp_next == count_ff;
            rsp_status_in = ms_pkg::STAT_OK;
            rp_in         = rp_next;
            state_in      = TS_IDLE;
         end
         TS_FEED: begin
            pend_in     = 1'b1;
            store_raddr = feed_take ? fptr_next[ms_pkg::ADDR_W-1:0]
                                    : fptr_ff[ms_pkg::ADDR_W-1:0];
            if (feed_take) begin
               fptr_in = fptr_next;
               if (flow[0].last) begin
                  pend_in  = 1'b0;
                  state_in = TS_DRAIN;
               end
            end
         end
         TS_DRAIN: begin
            // The last cell merges only after it holds the whole set, so every read of
            // the store is done before the first sorted value comes back.
            store_waddr = wptr_ff[ms_pkg::ADDR_W-1:0];
            store_wdata = flow[ms_pkg::LEVELS].data;
            if (flow[ms_pkg::LEVELS].valid) begin
               store_wen = 1'b1;
               wptr_in   = wptr_next;
               if (flow[ms_pkg::LEVELS].last) begin
                  sorted_in = 1'b1;
                  rp_in     = '0;
                  state_in  = TS_IDLE;
               end
            end
         end
         default: begin
            state_in = TS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TS_IDLE;
         count_ff     <= '0;
         rp_ff        <= '0;
         sorted_ff    <= 1'b0;
         fptr_ff      <= '0;
         pend_ff      <= 1'b0;
         wptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         sorted_ff    <= sorted_in;
         fptr_ff      <= fptr_in;
         pend_ff      <= pend_in;
         wptr_ff      <= wptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (store_wen) begin
         data_store[store_waddr] <= store_wdata;
      end
      store_rd_ff <= data_store[store_raddr];
   end

   // The merge chain. Cell g merges runs of 2**g values into runs of 2**(g+1); its two
   // run buffers are sized to match.
   for (genvar g = 0; g < ms_pkg::LEVELS; g++) begin : g_level
      localparam int AW = (g == 0) ? 1 : g;

      logic signed [ms_pkg::DATA_W-1:0] scratch_a [0:(1 << AW)-1];
      logic signed [ms_pkg::DATA_W-1:0] scratch_b [0:(1 << AW)-1];

      ms_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .level     (ms_pkg::LVL_W'(g)),
         .in_flow   (flow[g]),
         .in_ready  (flow_ready[g]),
         .out_flow  (flow[g+1]),
         .out_ready (flow_ready[g+1]),
         .ram_req   (ram_req[g]),
         .rd_a      (rd_a_ff[g]),
         .rd_b      (rd_b_ff[g])
      );

      always_ff @(posedge clock) begin
         if (ram_req[g].a_wen) begin
            scratch_a[ram_req[g].waddr[AW-1:0]] <= ram_req[g].wdata;
         end
         if (ram_req[g].b_wen) begin
            scratch_b[ram_req[g].waddr[AW-1:0]] <= ram_req[g].wdata;
         end
         rd_a_ff[g] <= scratch_a[ram_req[g].a_raddr[AW-1:0]];
         rd_b_ff[g] <= scratch_b[ram_req[g].b_raddr[AW-1:0]];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_last_out  = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

   // The store never counts more values than it can hold.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ms_pkg::CNT_W'(ms_pkg::MAX_ITEMS))
      else $error("value count exceeds the store capacity");

   // Pulls never read past the sorted set.
   a_pull_bound: assert property (@(posedge clock) disable iff (reset)
      sorted_ff |-> rp_ff <= count_ff)
      else $error("read pointer beyond the sorted set");

   // The chain gives back no more values than were fed in.
   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == TS_DRAIN && flow[ms_pkg::LEVELS].valid) |-> wptr_ff < count_ff)
      else $error("merge chain returned too many values");

   // The end of the set comes back exactly with the final value.
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == TS_DRAIN && flow[ms_pkg::LEVELS].valid && flow[ms_pkg::LEVELS].last)
      |-> wptr_next == count_ff)
      else $error("merge chain lost or repeated values");

endmodule
